// File: rtl/core/rspf_pkg.sv
`timescale 1ns / 1ps

package rspf_pkg;

    typedef enum logic [1:0] {
        CMD_BEGIN   = 2'd0,
        CMD_PAYLOAD = 2'd1,
        CMD_END     = 2'd2,
        CMD_HOST    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DRAIN = 2'd1,
        PH_SEND  = 2'd2,
        PH_WAIT  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_SENT    = 3'd0,
        ST_ACK     = 3'd1,
        ST_RESEND  = 3'd2,
        ST_GAVEUP  = 3'd3,
        ST_HOSTPKT = 3'd4,
        ST_NOTED   = 3'd5,
        ST_ORDER   = 3'd6
    } status_t;

    typedef struct packed {
        logic       is_wire;
        logic [7:0] wire_byte;
        status_t    status;
        logic       interrupt;
        logic       last;
    } result_t;

    localparam logic [7:0] CH_START     = 8'h24;  // '$'
    localparam logic [7:0] CH_HASH      = 8'h23;  // '#'
    localparam logic [7:0] CH_ESCAPE    = 8'h7d;  // '}'
    localparam logic [7:0] CH_STAR      = 8'h2a;  // '*'
    localparam logic [7:0] CH_ACK       = 8'h2b;  // '+'
    localparam logic [7:0] CH_NACK      = 8'h2d;  // '-'
    localparam logic [7:0] CH_CTRL_C    = 8'h03;
    localparam logic [7:0] ESCAPE_XOR   = 8'h20;
    localparam logic [7:0] RETRY_RESET  = 8'd10;
    localparam logic [7:0] NACK_MAX     = 8'hff;
    localparam logic [3:0] HEX_LAST_DIG = 4'd9;
    localparam logic [7:0] CH_ZERO      = 8'h30;  // '0'
    localparam logic [7:0] CH_LOWER_A   = 8'h61;  // 'a'

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib <= HEX_LAST_DIG) begin
            hex_char = CH_ZERO + {4'h0, nib};
        end else begin
            hex_char = CH_LOWER_A + {4'h0, nib} - 8'd10;
        end
    endfunction

    function automatic result_t mk_result(input logic wire_en, input logic [7:0] b,
                                          input status_t st, input logic intr);
        result_t r;
        r.is_wire   = wire_en;
        r.wire_byte = b;
        r.status    = st;
        r.interrupt = intr;
        r.last      = 1'b0;
        return r;
    endfunction

endpackage

// File: rtl/core/rsp_packet_framer_with_ack_core.sv
`timescale 1ns / 1ps

// Debugger packet framer with host acknowledgement tracking.
//
// Input channel (s_*): one request per command - begin, payload byte, end, or a
// byte received from the host. Result channel (m_*): zero to three results per
// request, each either a byte to put on the wire (is_wire) or a status word;
// m_last flags the final result of a request.
// Config channel (cfg_*): writes retry_limit, always ready; write it only while
// the block is idle.
//
// Output: a request's results are registered into the result buffer on acceptance.
// Throughput: one request per cycle for single-result requests while m_ready
// stays high; a request with several results holds off the next one while the
// three-slot result buffer drains one result per cycle. The next request is taken
// while the last result of the previous one is being handed off.
// Reset: phase idle, checksum, nack count and ctrl-C flag cleared, retry_limit
// back to 10, result buffer empty.
// Receiver stall: results hold in the buffer; s_ready drops until the buffer is
// down to its last result and m_ready is high.
module rsp_packet_framer_with_ack_core
    import rspf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [7:0] s_data_byte,
    input  logic       s_drain_first,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_wire,
    output logic [7:0] m_wire_byte,
    output logic [2:0] m_status,
    output logic       m_interrupt,
    output logic       m_last
);

    // Protocol state
    phase_t     phase_reg, phase_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] nack_reg, nack_next;
    logic       ctrlc_reg, ctrlc_next;
    logic [7:0] retry_reg;

    // Result buffer: slot 0 faces the output
    result_t    slot_reg [3];
    result_t    slot_next [3];
    logic [1:0] cnt_reg, cnt_next;

    // Results of the request at the input
    result_t    res [3];
    logic [1:0] res_n;

    logic       s_fire, m_fire;
    cmd_t       cmd;
    logic [7:0] b;
    logic [7:0] esc_b;
    logic       needs_esc;
    logic [7:0] nack_inc;

    assign cmd       = cmd_t'(s_cmd);
    assign b         = s_data_byte;
    assign esc_b     = b ^ ESCAPE_XOR;
    assign needs_esc = (b == CH_HASH) || (b == CH_START) || (b == CH_ESCAPE) || (b == CH_STAR);
    assign nack_inc  = (nack_reg == NACK_MAX) ? NACK_MAX : nack_reg + 8'd1;

    assign cfg_ready = 1'b1;
    assign m_valid   = (cnt_reg != 2'd0);
    // Take a new request when the buffer is empty or its last result leaves now
    assign s_ready   = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);
    assign s_fire    = s_valid && s_ready;
    assign m_fire    = m_valid && m_ready;

    assign m_is_wire   = slot_reg[0].is_wire;
    assign m_wire_byte = slot_reg[0].wire_byte;
    assign m_status    = slot_reg[0].status;
    assign m_interrupt = slot_reg[0].interrupt;
    assign m_last      = slot_reg[0].last;

    // Per-request decode: results and next protocol state
    always_comb begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        nack_next  = nack_reg;
        ctrlc_next = ctrlc_reg;
        res_n      = 2'd0;
        res[0]     = mk_result(1'b0, 8'h00, ST_SENT, 1'b0);
        res[1]     = res[0];
        res[2]     = res[0];

        case (cmd)
            CMD_BEGIN: begin
                if (phase_reg == PH_IDLE || phase_reg == PH_DRAIN) begin
                    sum_next = 8'h00;
                    if (phase_reg == PH_IDLE) begin
                        nack_next  = 8'h00;
                        ctrlc_next = 1'b0;
                    end
                    if (phase_reg == PH_IDLE && s_drain_first) begin
                        phase_next = PH_DRAIN;
                    end else begin
                        phase_next = PH_SEND;
                        res[0]     = mk_result(1'b1, CH_START, ST_SENT, 1'b0);
                        res_n      = 2'd1;
                    end
                end else begin
                    res[0] = mk_result(1'b0, 8'h00, ST_ORDER, 1'b0);
                    res_n  = 2'd1;
                end
            end
            CMD_PAYLOAD: begin
                if (phase_reg != PH_SEND) begin
                    res[0] = mk_result(1'b0, 8'h00, ST_ORDER, 1'b0);
                    res_n  = 2'd1;
                end else if (needs_esc) begin
                    res[0]   = mk_result(1'b1, CH_ESCAPE, ST_SENT, 1'b0);
                    res[1]   = mk_result(1'b1, esc_b, ST_SENT, 1'b0);
                    res_n    = 2'd2;
                    sum_next = sum_reg + CH_ESCAPE + esc_b;
                end else begin
                    res[0]   = mk_result(1'b1, b, ST_SENT, 1'b0);
                    res_n    = 2'd1;
                    sum_next = sum_reg + b;
                end
            end
            CMD_END: begin
                if (phase_reg != PH_SEND) begin
                    res[0] = mk_result(1'b0, 8'h00, ST_ORDER, 1'b0);
                    res_n  = 2'd1;
                end else begin
                    res[0]     = mk_result(1'b1, CH_HASH, ST_SENT, 1'b0);
                    res[1]     = mk_result(1'b1, hex_char(sum_reg[7:4]), ST_SENT, 1'b0);
                    res[2]     = mk_result(1'b1, hex_char(sum_reg[3:0]), ST_SENT, 1'b0);
                    res_n      = 2'd3;
                    phase_next = PH_WAIT;
                end
            end
            default: begin
                // Host byte; drop stray bytes and everything seen while idle
                if (phase_reg != PH_IDLE) begin
                    if (b == CH_CTRL_C) begin
                        ctrlc_next = 1'b1;
                        res[0]     = mk_result(1'b0, 8'h00, ST_NOTED, 1'b0);
                        res_n      = 2'd1;
                    end else if (b == CH_START &&
                                 (phase_reg == PH_DRAIN || phase_reg == PH_WAIT)) begin
                        res[0]     = mk_result(1'b0, 8'h00, ST_HOSTPKT, ctrlc_reg);
                        res_n      = 2'd1;
                        phase_next = PH_IDLE;
                    end else if (phase_reg == PH_WAIT && b == CH_ACK) begin
                        res[0]     = mk_result(1'b0, 8'h00, ST_ACK, ctrlc_reg);
                        res_n      = 2'd1;
                        phase_next = PH_IDLE;
                    end else if (phase_reg == PH_WAIT && b == CH_NACK) begin
                        nack_next = nack_inc;
                        res_n     = 2'd1;
                        if (nack_inc >= retry_reg) begin
                            res[0]     = mk_result(1'b0, 8'h00, ST_GAVEUP, ctrlc_reg);
                            phase_next = PH_IDLE;
                        end else begin
                            res[0]     = mk_result(1'b0, 8'h00, ST_RESEND, ctrlc_reg);
                            phase_next = PH_DRAIN;
                        end
                    end
                end
            end
        endcase

        // Flag the final result of this request
        case (res_n)
            2'd1:    res[0].last = 1'b1;
            2'd2:    res[1].last = 1'b1;
            2'd3:    res[2].last = 1'b1;
            default: ;
        endcase
    end

    // Result buffer: load on a new request, else shift one out per handoff
    always_comb begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (s_fire) begin
            slot_next = res;
            cnt_next  = res_n;
        end else if (m_fire) begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            cnt_next     = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            sum_reg   <= 8'h00;
            nack_reg  <= 8'h00;
            ctrlc_reg <= 1'b0;
            retry_reg <= RETRY_RESET;
            cnt_reg   <= 2'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                retry_reg <= cfg_data;
            end
            if (s_fire) begin
                phase_reg <= phase_next;
                sum_reg   <= sum_next;
                nack_reg  <= nack_next;
                ctrlc_reg <= ctrlc_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Payload slots need no reset
    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    // Assertions
    a_last_on_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && cnt_reg == 2'd1) |-> m_last)
        else $error("final buffered result lacks last flag");

    a_no_early_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && cnt_reg != 2'd1) |-> !m_last)
        else $error("last flag on a result that is not final");

    a_ready_only_low_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (cnt_reg <= 2'd1))
        else $error("request taken while results still queued");

    a_wait_keeps_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_WAIT) |=> $stable(sum_reg))
        else $error("checksum changed while waiting for host");

endmodule
